### hdl/register_command_framer_crc16_top_assert.svh
// Assertion macros for the command framer
`ifndef REGISTER_COMMAND_FRAMER_CRC16_TOP_ASSERT_SVH
`define REGISTER_COMMAND_FRAMER_CRC16_TOP_ASSERT_SVH

// check that cons holds in the same cycle as ante
`define RCF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framer assertion failed");

// check that cons holds in the cycle after ante
`define RCF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framer assertion failed");

`endif

### hdl/rcf_pkg.sv
package rcf_pkg;

    localparam int PAYLOAD_BYTES_MAX = 12;
    localparam int QUEUE_DEPTH_DEF   = 2;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 48;
    localparam logic [CFG_INDEX_W-1:0] CFG_USER_SERIAL    = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FACTORY_SERIAL = 1'b1;

    localparam logic [47:0] USER_SERIAL_RST    = 48'd91652491030577;
    localparam logic [31:0] FACTORY_SERIAL_RST = 32'd344522753;

    localparam logic [7:0] CMD_READ  = 8'h0A;
    localparam logic [7:0] CMD_WRITE = 8'h0B;

    localparam int POS_W = 5;
    localparam logic [POS_W-1:0] POS_FLEN_HI   = 5'd6;
    localparam logic [POS_W-1:0] POS_FLEN_LO   = 5'd7;
    localparam logic [POS_W-1:0] POS_CMD       = 5'd12;
    localparam logic [POS_W-1:0] POS_ADDR      = 5'd13;
    localparam logic [POS_W-1:0] POS_BODY      = 5'd14;
    localparam logic [POS_W-1:0] READ_BODY_LEN = 5'd2;
    localparam logic [7:0]       FLEN_OFFSET   = 8'd7;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    typedef struct packed {
        logic        action;
        logic [7:0]  reg_address;
        logic [15:0] count;
        logic [63:0] payload_low;
        logic [31:0] payload_high;
    } req_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
        logic       length_error;
    } rsp_t;

    typedef struct packed {
        logic             length_error;
        logic             action;
        logic [7:0]       reg_address;
        logic [15:0]      count;
        logic [POS_W-1:0] data_last;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DATA,
        BK_CRC_LO,
        BK_CRC_HI
    } bk_state_t;

endpackage

### hdl/rcf_front.sv
module rcf_front #(
    parameter int MAX_PAYLOAD_BYTES = rcf_pkg::PAYLOAD_BYTES_MAX
) (
    input  rcf_pkg::req_t                   req,
    input  logic                            req_valid,
    output logic                            req_stall,
    input  rcf_pkg::q_stat_t                q_stat,
    output logic                            push,
    output rcf_pkg::desc_t                  desc,
    output logic [MAX_PAYLOAD_BYTES*8-1:0]  payload
);
    import rcf_pkg::*;

    logic [95:0]      pay_all;
    logic             count_bad;
    logic [POS_W-1:0] body_len;

    assign pay_all   = {req.payload_high, req.payload_low};
    assign payload   = pay_all[MAX_PAYLOAD_BYTES*8-1:0];

    assign count_bad = (req.count < 16'd2) || (req.count > 16'(MAX_PAYLOAD_BYTES))
                       || req.count[0];
    assign body_len  = req.action ? req.count[POS_W-1:0] : READ_BODY_LEN;

    assign desc.length_error = req.action && count_bad;
    assign desc.action       = req.action;
    assign desc.reg_address  = req.reg_address;
    assign desc.count        = req.count;
    assign desc.data_last    = POS_ADDR + body_len;

    assign req_stall = q_stat.full;
    assign push      = req_valid && !q_stat.full;

endmodule

### hdl/rcf_queue.sv
module rcf_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rcf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output rcf_pkg::q_stat_t q_stat
);
    import rcf_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign q_stat.full  = (cnt_reg == CNT_FULL);
    assign q_stat.empty = (cnt_reg == '0);
    assign rd_data      = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### hdl/rcf_back.sv
module rcf_back #(
    parameter int MAX_PAYLOAD_BYTES = rcf_pkg::PAYLOAD_BYTES_MAX
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  rcf_pkg::desc_t                  desc,
    input  logic [MAX_PAYLOAD_BYTES*8-1:0]  payload,
    input  rcf_pkg::q_stat_t                q_stat,
    input  logic [47:0]                     user_serial,
    input  logic [31:0]                     factory_serial,
    output logic                            pop,
    output logic                            rsp_valid,
    input  logic                            rsp_stall,
    output rcf_pkg::rsp_t                   rsp
);
    import rcf_pkg::*;

    localparam int PIDX_W = $clog2(MAX_PAYLOAD_BYTES);

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    bk_state_t        state_reg, state_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      crc_reg, crc_next;
    rsp_t             rsp_reg, rsp_next;
    logic             rsp_valid_reg, rsp_valid_next;

    logic             advance;
    logic             emit;
    logic             load;
    logic             step;
    rsp_t             emit_rsp;
    logic [7:0]       data_byte;
    logic [7:0]       pay_bytes [MAX_PAYLOAD_BYTES];
    logic [POS_W-1:0] pos_off;
    logic [PIDX_W-1:0] body_idx;
    logic [47:0]      usr_shift;
    logic [31:0]      fac_shift;
    logic [7:0]       flen_lo;

    for (genvar g = 0; g < MAX_PAYLOAD_BYTES; g++)
    begin : g_pay
        assign pay_bytes[g] = payload[g*8 +: 8];
    end

    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign pos_off   = pos_reg - POS_BODY;
    assign body_idx  = pos_off[PIDX_W-1:0];
    assign usr_shift = user_serial >> {3'd5 - pos_reg[2:0], 3'b000};
    assign fac_shift = factory_serial >> {2'd3 - pos_reg[1:0], 3'b000};
    assign flen_lo   = {3'b000, desc.data_last} - FLEN_OFFSET;

    always_comb
    begin
        if (pos_reg < POS_FLEN_HI)
        begin
            data_byte = usr_shift[7:0];
        end
        else if (pos_reg == POS_FLEN_HI)
        begin
            data_byte = 8'h00;
        end
        else if (pos_reg == POS_FLEN_LO)
        begin
            data_byte = flen_lo;
        end
        else if (pos_reg < POS_CMD)
        begin
            data_byte = fac_shift[7:0];
        end
        else if (pos_reg == POS_CMD)
        begin
            data_byte = desc.action ? CMD_WRITE : CMD_READ;
        end
        else if (pos_reg == POS_ADDR)
        begin
            data_byte = desc.reg_address;
        end
        else if (desc.action)
        begin
            data_byte = pay_bytes[body_idx];
        end
        else
        begin
            data_byte = (pos_reg == POS_BODY) ? desc.count[15:8] : desc.count[7:0];
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty && advance && !desc.length_error)
                begin
                    state_next = BK_DATA;
                end
            end
            BK_DATA:
            begin
                if (advance && (pos_reg == desc.data_last))
                begin
                    state_next = BK_CRC_LO;
                end
            end
            BK_CRC_LO:
            begin
                if (advance)
                begin
                    state_next = BK_CRC_HI;
                end
            end
            BK_CRC_HI:
            begin
                if (advance)
                begin
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        emit     = 1'b0;
        emit_rsp = '0;
        pop      = 1'b0;
        load     = 1'b0;
        step     = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty && advance)
                begin
                    if (desc.length_error)
                    begin
                        emit                  = 1'b1;
                        emit_rsp.last_byte    = 1'b1;
                        emit_rsp.length_error = 1'b1;
                        pop                   = 1'b1;
                    end
                    else
                    begin
                        load = 1'b1;
                    end
                end
            end
            BK_DATA:
            begin
                if (advance)
                begin
                    emit                = 1'b1;
                    emit_rsp.frame_byte = data_byte;
                    step                = 1'b1;
                end
            end
            BK_CRC_LO:
            begin
                if (advance)
                begin
                    emit                = 1'b1;
                    emit_rsp.frame_byte = crc_reg[7:0];
                end
            end
            BK_CRC_HI:
            begin
                if (advance)
                begin
                    emit                = 1'b1;
                    emit_rsp.frame_byte = crc_reg[15:8];
                    emit_rsp.last_byte  = 1'b1;
                    pop                 = 1'b1;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (load)
        begin
            pos_next = '0;
            crc_next = CRC_INIT;
        end
        else if (step)
        begin
            pos_next = pos_reg + 1'b1;
            crc_next = crc16_byte(crc_reg, data_byte);
        end
        if (advance)
        begin
            rsp_valid_next = emit;
        end
        if (emit)
        begin
            rsp_next = emit_rsp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        crc_reg <= crc_next;
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### hdl/register_command_framer_crc16_top.sv
// Builds one serial command frame per request and sends it one byte per transfer:
// user serial (6 bytes), frame length (2 bytes, big-endian), factory serial (4 bytes),
// command, register address, body, then CRC-16/Modbus low byte first. A read frame
// is 18 bytes, a write frame with n payload bytes is 16+n bytes (at most 28), and a
// write with an odd count, a count below 2 or above MAX_PAYLOAD_BYTES gives one
// result with length_error set and no frame. The byte serializer sends one byte per
// cycle while rsp_stall is low and folds each data byte into the CRC as it goes;
// before each frame it loads the request at the head of the queue. A queue of
// QUEUE_DEPTH requests sits in front of the serializer, so new requests are taken
// while a frame is being sent. Serial numbers are written over the cfg channel
// (index 0 user serial, index 1 factory serial); the user must write them only while
// the block is idle, which the block itself does not enforce.
module register_command_framer_crc16_top #(
    parameter int MAX_PAYLOAD_BYTES = rcf_pkg::PAYLOAD_BYTES_MAX,
    parameter int QUEUE_DEPTH       = rcf_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_stall,
    input  rcf_pkg::req_t                      req,
    output logic                               rsp_valid,
    input  logic                               rsp_stall,
    output rcf_pkg::rsp_t                      rsp,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rcf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [rcf_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import rcf_pkg::*;

`include "register_command_framer_crc16_top_assert.svh"

    localparam int ENTRY_W = $bits(desc_t) + MAX_PAYLOAD_BYTES * 8;

    logic [47:0] user_serial_reg, user_serial_next;
    logic [31:0] factory_serial_reg, factory_serial_next;

    desc_t                          front_desc;
    logic [MAX_PAYLOAD_BYTES*8-1:0] front_payload;
    logic                           push;
    logic                           pop;
    q_stat_t                        q_stat;
    logic [ENTRY_W-1:0]             q_rd_data;
    desc_t                          head_desc;
    logic [MAX_PAYLOAD_BYTES*8-1:0] head_payload;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        user_serial_next    = user_serial_reg;
        factory_serial_next = factory_serial_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_USER_SERIAL:    user_serial_next    = cfg_data[47:0];
                CFG_FACTORY_SERIAL: factory_serial_next = cfg_data[31:0];
                default:            user_serial_next    = user_serial_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            user_serial_reg    <= USER_SERIAL_RST;
            factory_serial_reg <= FACTORY_SERIAL_RST;
        end
        else
        begin
            user_serial_reg    <= user_serial_next;
            factory_serial_reg <= factory_serial_next;
        end
    end

    rcf_front #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_front (
        .req       (req),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .q_stat    (q_stat),
        .push      (push),
        .desc      (front_desc),
        .payload   (front_payload)
    );

    rcf_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data ({front_desc, front_payload}),
        .pop     (pop),
        .rd_data (q_rd_data),
        .q_stat  (q_stat)
    );

    assign head_desc    = q_rd_data[ENTRY_W-1 -: $bits(desc_t)];
    assign head_payload = q_rd_data[MAX_PAYLOAD_BYTES*8-1:0];

    rcf_back #(
        .MAX_PAYLOAD_BYTES (MAX_PAYLOAD_BYTES)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .desc           (head_desc),
        .payload        (head_payload),
        .q_stat         (q_stat),
        .user_serial    (user_serial_reg),
        .factory_serial (factory_serial_reg),
        .pop            (pop),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp            (rsp)
    );

    `RCF_ASSERT_NOW(a_err_single, rsp_valid && rsp.length_error,
                    rsp.last_byte && (rsp.frame_byte == 8'h00))
    `RCF_ASSERT_NOW(a_pop_nonempty, pop, !q_stat.empty)
    `RCF_ASSERT_NOW(a_no_stall_empty, q_stat.empty, !req_stall)
    `RCF_ASSERT_NEXT(a_pop_drains, pop && !push && q_stat.full, !q_stat.full)

endmodule
